// ===== hw/rtl/ptach_pkg.sv =====
// Shared types and constants for the period tachometer.
package ptach_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int PPR_W   = 8;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int SPEED_W = 30;

  // Fixed-point speed scaling
  localparam int FRAC_BITS = 4;
  localparam int NUM_W     = 26 + FRAC_BITS;
  localparam logic [NUM_W-1:0] DIV_NUM = NUM_W'(64'd60000000 << FRAC_BITS);
  localparam int DEN_W     = TIME_W + PPR_W;
  localparam int STEP_W    = $clog2(NUM_W + 1);

  // Timeout limit in microseconds: timeout_ms * 1000 + 999
  localparam int US_PER_MS = 1000;
  localparam int LIM_W     = 26;

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(1500);
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = CFG_W'(2000);
  localparam logic [PPR_W-1:0] PPR_RST      = PPR_W'(1);

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PPR      = 2'd2;

  // Item kinds
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Job queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_FEW     = 2'd1,
    ST_ZERO    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic              taken;
    status_t           status;
    logic [CNT_W-1:0]  total;
    logic              div;
    logic [TIME_W-1:0] eff;
    logic [PPR_W-1:0]  ppr;
  } job_t;

endpackage

// ===== hw/rtl/ptach_front.sv =====
// Front part: configuration, pulse debounce, stamp history and read classification.
module ptach_front
  import ptach_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              accept,
  input  logic              cmd,
  input  logic [TIME_W-1:0] time_us,
  output job_t              job
);

  logic [CFG_W-1:0]  debounce;
  logic [LIM_W-1:0]  limit;
  logic [PPR_W-1:0]  ppr;
  logic [TIME_W-1:0] last_stamp;
  logic [TIME_W-1:0] prior_stamp;
  logic [1:0]        stamps_seen;
  logic [CNT_W-1:0]  accepted_count;

  logic [TIME_W-1:0] since_last;
  logic [TIME_W-1:0] period;
  logic              pulse_ok;
  logic [CNT_W-1:0]  count_next;

  // Write configuration; keep the timeout as a limit in microseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce <= DEBOUNCE_RST;
      limit    <= LIM_W'(TIMEOUT_RST) * LIM_W'(US_PER_MS) + LIM_W'(US_PER_MS - 1);
      ppr      <= PPR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_DEBOUNCE: debounce <= cfg_data;
        CFG_TIMEOUT:  limit <= LIM_W'(cfg_data) * LIM_W'(US_PER_MS) + LIM_W'(US_PER_MS - 1);
        CFG_PPR:      ppr <= cfg_data[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Time since the last pulse and between the last two pulses
  assign since_last = time_us - last_stamp;
  assign period     = last_stamp - prior_stamp;
  assign pulse_ok   = (stamps_seen == 2'd0) || (since_last >= TIME_W'(debounce));
  assign count_next = accepted_count + CNT_W'(1);

  // Advance stamp history on an accepted pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp     <= '0;
      prior_stamp    <= '0;
      stamps_seen    <= '0;
      accepted_count <= '0;
    end else if (accept && cmd == CMD_PULSE && pulse_ok) begin
      prior_stamp    <= last_stamp;
      last_stamp     <= time_us;
      accepted_count <= count_next;
      if (stamps_seen != 2'd2) begin
        stamps_seen <= stamps_seen + 2'd1;
      end
    end
  end

  // Classify the request
  always_comb begin
    job        = '0;
    job.total  = accepted_count;
    job.eff    = (since_last > period) ? since_last : period;
    job.ppr    = (ppr == '0) ? PPR_W'(1) : ppr;
    job.status = ST_RUN;
    if (cmd == CMD_PULSE) begin
      if (pulse_ok) begin
        job.taken = 1'b1;
        job.total = count_next;
      end
    end else if (stamps_seen != 2'd2) begin
      job.status = ST_FEW;
    end else if (period == '0) begin
      job.status = ST_ZERO;
    end else if (since_last > TIME_W'(limit)) begin
      job.status = ST_TIMEOUT;
    end else begin
      job.div = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/ptach_queue.sv =====
// Short job queue between the front and back parts.
module ptach_queue
  import ptach_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  output logic valid,
  input  logic rd_en,
  output job_t rd_job
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign valid  = (count != '0);
  assign rd_job = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/ptach_back.sv =====
// Back part: denominator multiply, serial speed divider and result register.
module ptach_back
  import ptach_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  job_t               q_job,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic               pulse_taken,
  output logic [SPEED_W-1:0] speed_q4,
  output logic [1:0]         read_status,
  output logic [CNT_W-1:0]   pulse_total
);

  back_state_t        state;
  back_state_t        state_next;

  // Work registers
  job_t               work;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [NUM_W-1:0]   num;
  logic [SPEED_W-1:0] quo;
  logic [STEP_W-1:0]  steps;

  // Result register
  logic               res_valid;

  logic               out_free;
  logic               load_direct;
  logic               load_quo;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [DEN_W:0]     rem_sub;

  assign out_free = !res_valid || pop;
  assign empty    = !res_valid;

  // One restoring division step
  assign rem_sh  = {rem, num[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  // Next state and handshakes
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    load_direct = 1'b0;
    load_quo    = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_job.div) begin
            q_pop      = 1'b1;
            state_next = BK_MUL;
          end else if (out_free) begin
            q_pop       = 1'b1;
            load_direct = 1'b1;
          end
        end
      end
      BK_MUL: state_next = BK_DIV;
      BK_DIV: begin
        if (steps == STEP_W'(1)) begin
          state_next = BK_HOLD;
        end
      end
      BK_HOLD: begin
        if (out_free) begin
          load_quo   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the job, form the denominator, then shift out quotient bits
  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_job;
    end
    if (state == BK_MUL) begin
      den   <= DEN_W'(work.eff) * DEN_W'(work.ppr);
      rem   <= '0;
      num   <= DIV_NUM;
      quo   <= '0;
      steps <= STEP_W'(NUM_W);
    end else if (state == BK_DIV) begin
      rem   <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num   <= num << 1;
      quo   <= {quo[SPEED_W-2:0], ge};
      steps <= steps - STEP_W'(1);
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_direct || load_quo) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      pulse_taken <= q_job.taken;
      speed_q4    <= '0;
      read_status <= q_job.status;
      pulse_total <= q_job.total;
    end else if (load_quo) begin
      pulse_taken <= work.taken;
      speed_q4    <= quo;
      read_status <= work.status;
      pulse_total <= work.total;
    end
  end

endmodule

// ===== hw/rtl/period_tachometer_with_decay_unit.sv =====
// Period tachometer top level: front classifier, job queue and divider back end.
// Path: a pulse or a read that needs no division is written into the job queue, then
// into the result register once that is free; a running read goes through the queue,
// the multiply, the one-bit-a-cycle restoring divider and the hold state.
// Throughput: one pulse per cycle while the queue is not full; the divider takes one read at a time.
// Reset: synchronous rst restores register defaults, clears history, queue and result.
module period_tachometer_with_decay_unit
  import ptach_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [TIME_W-1:0]  time_us,
  output logic               empty,
  input  logic               pop,
  output logic               pulse_taken,
  output logic [SPEED_W-1:0] speed_q4,
  output logic [1:0]         read_status,
  output logic [CNT_W-1:0]   pulse_total
);

  logic accept;
  job_t front_job;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  assign accept = push && !full;

  ptach_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .time_us   (time_us),
    .job       (front_job)
  );

  ptach_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (accept),
    .wr_job (front_job),
    .full   (full),
    .valid  (q_valid),
    .rd_en  (q_pop),
    .rd_job (q_job)
  );

  ptach_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .pulse_taken (pulse_taken),
    .speed_q4    (speed_q4),
    .read_status (read_status),
    .pulse_total (pulse_total)
  );

endmodule

// ===== hw/rtl/ptach_checker.sv =====
// Port-level checker for the period tachometer, bound to the top level.
module ptach_checker
  import ptach_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input logic               pulse_taken,
  input logic [SPEED_W-1:0] speed_q4,
  input logic [1:0]         read_status
);

  // Reset drops any waiting result
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // A nonzero speed only comes from a running read
  a_speed_running: assert property (@(posedge clk) disable iff (rst)
    (!empty && speed_q4 != '0) |-> (read_status == ST_RUN && !pulse_taken))
    else $error("speed on a non-running result");

  // An accepted pulse carries no read status
  a_pulse_status: assert property (@(posedge clk) disable iff (rst)
    (!empty && pulse_taken) |-> (read_status == ST_RUN && speed_q4 == '0))
    else $error("pulse result with read fields set");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(speed_q4) && $stable(read_status)))
    else $error("result changed while waiting");

endmodule

bind period_tachometer_with_decay_unit ptach_checker u_ptach_checker (.*);
